// ===== rtl/tsdq_pkg.sv =====
// Shared types and constants of the task sleep delta queue.
`timescale 1ns / 1ps

package tsdq_pkg;

	localparam int TASK_W   = 4;
	localparam int PRIO_W   = 8;
	localparam int DELTA_W  = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int NUM_IDS  = 16;

	// Request kinds on the input tuser
	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

	// Result codes on the output tuser
	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECT    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_WOKEN     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IDLE_TICK = 2'd3;

	// Operation broadcast to every cell
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REMOVE,
		OP_POP,
		OP_HEAD_DEC
	} cell_op_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_WAKE
	} fsm_t;

	typedef struct packed {
		cell_op_t            op;
		logic [TASK_W-1:0]   task_id;
		logic [PRIO_W-1:0]   prio;
	} cell_cmd_t;

	// Contents of one slot as seen by its neighbours
	typedef struct packed {
		logic                valid;
		logic [TASK_W-1:0]   task_id;
		logic [PRIO_W-1:0]   prio;
		logic [DELTA_W-1:0]  delta;
	} cell_data_t;

	// Search token that walks down the chain, carrying the remaining wait
	typedef struct packed {
		logic                tok;
		logic [DELTA_W-1:0]  rem;
	} tok_t;

endpackage

// ===== rtl/tsdq_cell.sv =====
// One slot of the delta list: task, priority, relative wait and search token.
`timescale 1ns / 1ps

module tsdq_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head,
	input  tsdq_pkg::cell_cmd_t  cmd,
	input  tsdq_pkg::tok_t       tok_in,
	output tsdq_pkg::tok_t       tok_out,
	input  tsdq_pkg::cell_data_t left,
	output tsdq_pkg::cell_data_t fwd,
	input  tsdq_pkg::cell_data_t right,
	output tsdq_pkg::cell_data_t own,
	input  logic                 before_in,
	output logic                 before_out,
	output logic                 hit
);

	logic                            valid_q;
	logic [tsdq_pkg::TASK_W-1:0]     task_q;
	logic [tsdq_pkg::PRIO_W-1:0]     prio_q;
	logic [tsdq_pkg::DELTA_W-1:0]    delta_q;
	logic                            tok_q;
	logic [tsdq_pkg::DELTA_W-1:0]    rem_q;

	logic                            match;
	logic                            at;
	logic                            stop;
	tsdq_pkg::cell_data_t            nxt;

	// Locate this slot as the point of the current operation
	always_comb begin
		match = valid_q && (cmd.task_id == task_q);
		at    = ((cmd.op == tsdq_pkg::OP_INSERT) && tok_q) ||
		        ((cmd.op == tsdq_pkg::OP_REMOVE) && match) ||
		        ((cmd.op == tsdq_pkg::OP_POP) && head);
		before_out = before_in || at;
	end

	// Stop the token at an empty slot, a later deadline, or a tie with larger prio
	always_comb begin
		stop = !valid_q || (delta_q > rem_q) ||
		       ((delta_q == rem_q) && (cmd.prio < prio_q));
		hit         = tok_q && stop;
		tok_out.tok = tok_q && !stop;
		tok_out.rem = rem_q - delta_q;
	end

	// Offer contents to both neighbours; the successor of an insert loses the new wait
	always_comb begin
		own.valid   = valid_q;
		own.task_id = task_q;
		own.prio    = prio_q;
		own.delta   = delta_q;
		fwd         = own;
		if (tok_q) begin
			fwd.delta = delta_q - rem_q;
		end
	end

	// Shift, load or count down
	always_comb begin
		nxt = own;
		case (cmd.op)
			tsdq_pkg::OP_INSERT: begin
				if (at) begin
					nxt.valid   = 1'b1;
					nxt.task_id = cmd.task_id;
					nxt.prio    = cmd.prio;
					nxt.delta   = rem_q;
				end else if (before_in) begin
					nxt = left;
				end
			end
			tsdq_pkg::OP_REMOVE, tsdq_pkg::OP_POP: begin
				if (at) begin
					nxt       = right;
					nxt.delta = right.delta + delta_q;
				end else if (before_in) begin
					nxt = right;
				end
			end
			tsdq_pkg::OP_HEAD_DEC: begin
				if (head) begin
					nxt.delta = (delta_q > tsdq_pkg::DELTA_W'(1)) ?
					            delta_q - tsdq_pkg::DELTA_W'(1) : '0;
				end
			end
			default: begin
				nxt = own;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
			tok_q   <= tok_in.tok;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		task_q  <= nxt.task_id;
		prio_q  <= nxt.prio;
		delta_q <= nxt.delta;
		rem_q   <= tok_in.rem;
	end

endmodule

// ===== rtl/tsdq_ctrl.sv =====
// Sequencer: request intake, sleep flags, queue length and result register.
`timescale 1ns / 1ps

module tsdq_ctrl #(
	parameter int MAX_TASKS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tsdq_pkg::KIND_W-1:0]       in_kind,
	input  logic [tsdq_pkg::TASK_W-1:0]       in_task,
	input  logic [tsdq_pkg::DELTA_W-1:0]      in_ticks,
	input  logic [tsdq_pkg::PRIO_W-1:0]       in_prio,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tsdq_pkg::STATUS_W-1:0]     out_status,
	output logic [tsdq_pkg::TASK_W-1:0]       out_task,
	output logic                              out_last,
	input  tsdq_pkg::cell_data_t              head,
	input  tsdq_pkg::cell_data_t              second,
	input  logic                              hit,
	output tsdq_pkg::cell_cmd_t               cmd,
	output tsdq_pkg::tok_t                    start
);

	localparam int LW = $clog2(MAX_TASKS + 1);

	tsdq_pkg::fsm_t                  state_q, state_nxt;
	logic [LW-1:0]                   len_q;
	logic [tsdq_pkg::NUM_IDS-1:0]    sleep_q;
	logic [tsdq_pkg::TASK_W-1:0]     req_task_q;
	logic [tsdq_pkg::PRIO_W-1:0]     req_prio_q;
	logic                            m_valid_q;
	logic [tsdq_pkg::STATUS_W-1:0]   status_q;
	logic [tsdq_pkg::TASK_W-1:0]     task_out_q;
	logic                            last_q;

	logic                            out_free;
	logic                            take;
	logic                            full;
	logic                            wake_last;
	logic                            emit;
	logic [tsdq_pkg::STATUS_W-1:0]   emit_status;
	logic [tsdq_pkg::TASK_W-1:0]     emit_task;
	logic                            emit_last;
	logic                            len_inc, len_dec;
	logic                            flag_set, flag_clr;
	logic [tsdq_pkg::TASK_W-1:0]     flag_idx;

	assign out_free  = !m_valid_q || out_ready;
	assign in_ready  = (state_q == tsdq_pkg::S_IDLE) && out_free;
	assign take      = in_valid && in_ready;
	assign full      = (len_q == LW'(MAX_TASKS));
	assign wake_last = !(second.valid && (second.delta == '0));

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tsdq_pkg::S_IDLE: begin
				if (take) begin
					if ((in_kind == tsdq_pkg::KIND_ADD) && !sleep_q[in_task] && !full) begin
						state_nxt = tsdq_pkg::S_WALK;
					end else if ((in_kind == tsdq_pkg::KIND_TICK) && head.valid &&
					             (head.delta <= tsdq_pkg::DELTA_W'(1))) begin
						state_nxt = tsdq_pkg::S_WAKE;
					end
				end
			end
			tsdq_pkg::S_WALK: begin
				if (hit) begin
					state_nxt = tsdq_pkg::S_IDLE;
				end
			end
			tsdq_pkg::S_WAKE: begin
				if (out_free && wake_last) begin
					state_nxt = tsdq_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = tsdq_pkg::S_IDLE;
			end
		endcase
	end

	// Cell commands, results and bookkeeping
	always_comb begin
		cmd.op      = tsdq_pkg::OP_HOLD;
		cmd.task_id = req_task_q;
		cmd.prio    = req_prio_q;
		start.tok   = 1'b0;
		start.rem   = in_ticks;
		emit        = 1'b0;
		emit_status = tsdq_pkg::ST_DONE;
		emit_task   = '0;
		emit_last   = 1'b1;
		len_inc     = 1'b0;
		len_dec     = 1'b0;
		flag_set    = 1'b0;
		flag_clr    = 1'b0;
		flag_idx    = req_task_q;
		case (state_q)
			tsdq_pkg::S_IDLE: begin
				cmd.task_id = in_task;
				flag_idx    = in_task;
				if (take) begin
					emit = 1'b1;
					case (in_kind)
						tsdq_pkg::KIND_ADD: begin
							if (sleep_q[in_task] || full) begin
								emit_status = tsdq_pkg::ST_REJECT;
							end else begin
								emit      = 1'b0;
								start.tok = 1'b1;
							end
						end
						tsdq_pkg::KIND_REMOVE: begin
							if (sleep_q[in_task]) begin
								cmd.op   = tsdq_pkg::OP_REMOVE;
								len_dec  = 1'b1;
								flag_clr = 1'b1;
							end
						end
						tsdq_pkg::KIND_TICK: begin
							emit_status = tsdq_pkg::ST_IDLE_TICK;
							if (head.valid) begin
								cmd.op = tsdq_pkg::OP_HEAD_DEC;
								if (head.delta <= tsdq_pkg::DELTA_W'(1)) begin
									emit = 1'b0;
								end
							end
						end
						default: begin
							emit_status = tsdq_pkg::ST_DONE;
						end
					endcase
				end
			end
			tsdq_pkg::S_WALK: begin
				if (hit) begin
					cmd.op   = tsdq_pkg::OP_INSERT;
					emit     = 1'b1;
					len_inc  = 1'b1;
					flag_set = 1'b1;
				end
			end
			tsdq_pkg::S_WAKE: begin
				flag_idx = head.task_id;
				if (out_free) begin
					cmd.op      = tsdq_pkg::OP_POP;
					emit        = 1'b1;
					emit_status = tsdq_pkg::ST_WOKEN;
					emit_task   = head.task_id;
					emit_last   = wake_last;
					len_dec     = 1'b1;
					flag_clr    = 1'b1;
				end
			end
			default: begin
				cmd.op = tsdq_pkg::OP_HOLD;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tsdq_pkg::S_IDLE;
			len_q     <= '0;
			sleep_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (len_inc) begin
				len_q <= len_q + LW'(1);
			end else if (len_dec) begin
				len_q <= len_q - LW'(1);
			end
			if (flag_set) begin
				sleep_q[flag_idx] <= 1'b1;
			end else if (flag_clr) begin
				sleep_q[flag_idx] <= 1'b0;
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (take) begin
			req_task_q <= in_task;
			req_prio_q <= in_prio;
		end
		if (emit) begin
			status_q   <= emit_status;
			task_out_q <= emit_task;
			last_q     <= emit_last;
		end
	end

	assign out_valid  = m_valid_q;
	assign out_status = status_q;
	assign out_task   = task_out_q;
	assign out_last   = last_q;

	// Flags and length agree
	a_flags_len: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(sleep_q) == int'(len_q))
		else $error("sleep flags disagree with queue length");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_TASKS))
		else $error("queue length beyond capacity");

	a_walk_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tsdq_pkg::S_WALK) |-> !m_valid_q)
		else $error("result pending during insert search");

	a_wake_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tsdq_pkg::S_WAKE) |-> (head.valid && (head.delta == '0)))
		else $error("wake with no expired head");

	a_hit_walk: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> (state_q == tsdq_pkg::S_WALK))
		else $error("search token outside insert search");

endmodule

// ===== rtl/task_sleep_delta_queue.sv =====
// Top level of the task sleep delta queue: sequencer and chain of slot cells.
`timescale 1ns / 1ps

// Sorted sleep queue kept as a delta list in a chain of MAX_TASKS slot cells.
// Remove, ignored kinds, rejected adds and ticks that wake nothing give their
// single result in the cycle after acceptance. An add walks a search token
// down the chain one cell per cycle and inserts where the token stops. A tick
// that expires the head counts it down, then pops the woken tasks in order,
// each result being one beat that waits for m_tready. One request is in flight
// at a time; s_tready is low while it is worked on.

module task_sleep_delta_queue #(
	parameter int MAX_TASKS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // task_req[3:0], ticks[35:4], priority_req[43:36], zero
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // woken_task[3:0], zero
	output logic        m_tlast,
	output logic [1:0]  m_tuser   // status[1:0]
);

	tsdq_pkg::cell_cmd_t              cmd;
	tsdq_pkg::tok_t                   start;
	tsdq_pkg::tok_t                   tok_w    [MAX_TASKS+1];
	tsdq_pkg::cell_data_t             fwd_w    [MAX_TASKS+1];
	tsdq_pkg::cell_data_t             own_w    [MAX_TASKS+1];
	logic [MAX_TASKS:0]               before_w;
	logic [MAX_TASKS-1:0]             hit_w;
	logic [tsdq_pkg::TASK_W-1:0]      woken;

	// Chain ends: the search token and no data enter from the left, an empty slot from the right
	assign tok_w[0]            = start;
	assign fwd_w[0]            = '0;
	assign before_w[0]         = 1'b0;
	assign own_w[MAX_TASKS]    = '0;

	tsdq_ctrl #(
		.MAX_TASKS(MAX_TASKS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (s_tuser),
		.in_task    (s_tdata[3:0]),
		.in_ticks   (s_tdata[35:4]),
		.in_prio    (s_tdata[43:36]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_task   (woken),
		.out_last   (m_tlast),
		.head       (own_w[0]),
		.second     (own_w[1]),
		.hit        (|hit_w),
		.cmd        (cmd),
		.start      (start)
	);

	assign m_tdata = {4'b0000, woken};

	// Row of slot cells, head first
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		tsdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.head       (i == 0),
			.cmd        (cmd),
			.tok_in     (tok_w[i]),
			.tok_out    (tok_w[i+1]),
			.left       (fwd_w[i]),
			.fwd        (fwd_w[i+1]),
			.right      (own_w[i+1]),
			.own        (own_w[i]),
			.before_in  (before_w[i]),
			.before_out (before_w[i+1]),
			.hit        (hit_w[i])
		);
	end

endmodule
